// ----- src/sv39ptw_pkg.sv -----
// shared types and constants for the sv39 page table walker
// no dependencies; used by the channel interfaces and the top level
package sv39ptw_pkg;

  localparam int NUM_FRAMES_DEF = 16;
  localparam int LEVELS         = 3;
  localparam int IDX_W          = 9;
  localparam int ENTRIES        = 512;
  localparam int VPN_W          = LEVELS * IDX_W;
  localparam int PPN_W          = 44;
  localparam int FLAGS_W        = 8;
  localparam int ENTRY_W        = PPN_W + FLAGS_W;
  localparam int CMD_W          = 2;
  localparam int STATUS_W       = 3;
  localparam int LVL_W          = 2;

  localparam logic [PPN_W-1:0]   FRAME_BASE_RST = PPN_W'(524288);
  localparam logic [FLAGS_W-1:0] FLAG_VALID     = FLAGS_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TRANSLATE = 2'd0,
    CMD_MAP       = 2'd1,
    CMD_UNMAP     = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_NOT_MAPPED  = 3'd1,
    STAT_ALREADY     = 3'd2,
    STAT_NO_FRAMES   = 3'd3,
    STAT_OUTSIDE     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DONE
  } state_t;

  // table index of one walk level, root level first
  function automatic logic [IDX_W-1:0] level_index(input logic [VPN_W-1:0] vpn,
                                                   input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = vpn[3*IDX_W-1:2*IDX_W];
      2'd1:    idx = vpn[2*IDX_W-1:IDX_W];
      default: idx = vpn[IDX_W-1:0];
    endcase
    return idx;
  endfunction

endpackage

// ----- src/sv39ptw_if.sv -----
// valid/ready channel interfaces: request, response and configuration write
// depends on sv39ptw_pkg for payload widths
interface sv39ptw_req_if;
  import sv39ptw_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [VPN_W-1:0]   vpn;
  logic [PPN_W-1:0]   target_ppn;
  logic [FLAGS_W-1:0] leaf_flags;
  modport source (output valid, cmd, vpn, target_ppn, leaf_flags, input ready);
  modport sink   (input valid, cmd, vpn, target_ppn, leaf_flags, output ready);
endinterface

interface sv39ptw_rsp_if;
  import sv39ptw_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PPN_W-1:0]    out_ppn;
  logic [FLAGS_W-1:0]  out_flags;
  modport source (output valid, status, out_ppn, out_flags, input ready);
  modport sink   (input valid, status, out_ppn, out_flags, output ready);
endinterface

interface sv39ptw_cfg_if;
  import sv39ptw_pkg::*;
  logic             valid;
  logic             ready;
  logic [PPN_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- src/sv39_page_table_walker_top.sv -----
// sv39 page table walker: three-level walk over a local frame store
// a full walk issues one read per level and then registers the result in the output register;
// the walk stops early on a failure, and the unused command goes straight to the hand-off
// requests are taken one at a time: accept, three dependent reads, result hand-off
// reset: a clearing pass zeroes every entry of the store (NUM_FRAMES*512, 8192 by default),
// with req.ready low; cfg writes are taken throughout
// depends on sv39ptw_pkg and sv39ptw_if
module sv39_page_table_walker_top #(
  parameter int NUM_FRAMES = sv39ptw_pkg::NUM_FRAMES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  sv39ptw_req_if.sink     req,
  sv39ptw_rsp_if.source   rsp,
  sv39ptw_cfg_if.sink     cfg
);
  import sv39ptw_pkg::*;

  localparam int FW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int NW    = $clog2(NUM_FRAMES + 1);
  localparam int AW    = FW + IDX_W;
  localparam int DEPTH = NUM_FRAMES * ENTRIES;

  // entry store
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // control and request registers
  state_t             state, state_next;
  logic [PPN_W-1:0]   frame_base;
  logic [NW-1:0]      nff, nff_next;
  logic [LVL_W-1:0]   lvl, lvl_next;
  logic [FW-1:0]      frame, frame_next;
  cmd_t               cmd;
  logic [VPN_W-1:0]   vpn;
  logic [PPN_W-1:0]   tppn;
  logic [FLAGS_W-1:0] flags;
  logic [AW-1:0]      clr_addr;
  status_t            res_status, res_status_next;
  logic [PPN_W-1:0]   res_ppn, res_ppn_next;
  logic [FLAGS_W-1:0] res_flags, res_flags_next;
  logic               load_req;
  logic               load_out;
  logic               out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [PPN_W-1:0]   out_ppn;
  logic [FLAGS_W-1:0] out_flags;

  // entry fields of the word just read
  logic               e_valid;
  logic [PPN_W-1:0]   e_ppn;
  logic [PPN_W-1:0]   e_off;
  logic [PPN_W-1:0]   new_ppn;

  assign e_valid = rdata[0];
  assign e_ppn   = rdata[ENTRY_W-1:FLAGS_W];
  assign e_off   = e_ppn - frame_base;
  assign new_ppn = frame_base + PPN_W'(nff);

  // store port with write-to-read forwarding on the same entry
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      if (mem_we && (mem_waddr == mem_raddr)) begin
        rdata <= mem_wdata;
      end else begin
        rdata <= mem[mem_raddr];
      end
    end
  end

  // configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= FRAME_BASE_RST;
    end else if (cfg.valid) begin
      frame_base <= cfg.data;
    end
  end

  // state and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      nff      <= NW'(1);
      clr_addr <= '0;
      lvl      <= '0;
      frame    <= '0;
    end else begin
      state <= state_next;
      nff   <= nff_next;
      lvl   <= lvl_next;
      frame <= frame_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // request capture and pending result
  always_ff @(posedge clk) begin
    if (load_req) begin
      cmd   <= cmd_t'(req.cmd);
      vpn   <= req.vpn;
      tppn  <= req.target_ppn;
      flags <= req.leaf_flags;
    end
    res_status <= res_status_next;
    res_ppn    <= res_ppn_next;
    res_flags  <= res_flags_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_ppn    <= res_ppn;
      out_flags  <= res_flags;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.out_ppn   = out_ppn;
  assign rsp.out_flags = out_flags;
  assign req.ready     = (state == S_IDLE);

  // next state, store accesses and results
  always_comb begin
    state_next      = state;
    nff_next        = nff;
    lvl_next        = lvl;
    frame_next      = frame;
    res_status_next = res_status;
    res_ppn_next    = res_ppn;
    res_flags_next  = res_flags;
    load_req        = 1'b0;
    load_out        = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = {frame, level_index(vpn, lvl)};
    mem_raddr       = '0;
    mem_wdata       = '0;

    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req.valid) begin
          load_req        = 1'b1;
          res_status_next = STAT_OK;
          res_ppn_next    = '0;
          res_flags_next  = '0;
          if ((req.cmd == CMD_TRANSLATE) || (req.cmd == CMD_MAP) ||
              (req.cmd == CMD_UNMAP)) begin
            // root read
            mem_re     = 1'b1;
            mem_raddr  = {FW'(0), level_index(req.vpn, LVL_W'(0))};
            lvl_next   = '0;
            frame_next = '0;
            state_next = S_CHECK;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_CHECK: begin
        if (lvl != LVL_W'(LEVELS - 1)) begin
          // table level: follow, create or fail
          if (!e_valid) begin
            if (cmd == CMD_TRANSLATE) begin
              res_status_next = STAT_NOT_MAPPED;
              state_next      = S_DONE;
            end else if (nff >= NW'(NUM_FRAMES)) begin
              res_status_next = STAT_NO_FRAMES;
              state_next      = S_DONE;
            end else begin
              mem_we     = 1'b1;
              mem_wdata  = {new_ppn, FLAG_VALID};
              nff_next   = nff + NW'(1);
              frame_next = nff[FW-1:0];
              lvl_next   = lvl + LVL_W'(1);
              mem_re     = 1'b1;
              mem_raddr  = {nff[FW-1:0], level_index(vpn, lvl + LVL_W'(1))};
            end
          end else if (e_off >= PPN_W'(NUM_FRAMES)) begin
            res_status_next = STAT_OUTSIDE;
            state_next      = S_DONE;
          end else begin
            frame_next = e_off[FW-1:0];
            lvl_next   = lvl + LVL_W'(1);
            mem_re     = 1'b1;
            mem_raddr  = {e_off[FW-1:0], level_index(vpn, lvl + LVL_W'(1))};
          end
        end else begin
          // leaf level
          state_next = S_DONE;
          case (cmd)
            CMD_TRANSLATE: begin
              if (e_valid) begin
                res_ppn_next   = e_ppn;
                res_flags_next = rdata[FLAGS_W-1:0];
              end else begin
                res_status_next = STAT_NOT_MAPPED;
              end
            end
            CMD_MAP: begin
              if (e_valid) begin
                res_status_next = STAT_ALREADY;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = {tppn, flags | FLAG_VALID};
              end
            end
            CMD_UNMAP: begin
              if (e_valid) begin
                mem_we    = 1'b1;
                mem_wdata = '0;
              end else begin
                res_status_next = STAT_NOT_MAPPED;
              end
            end
            default: begin
              res_status_next = STAT_OK;
            end
          endcase
        end
      end

      S_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
